[rtl/adf_pkg.sv]
// Shared constants and types for the address frame deframer.
package adf_pkg;

    localparam int          PAYLOAD_BYTES_DEF = 8;
    localparam int          PAYLOAD_BYTES_MAX = 8;
    localparam logic [7:0]  START_BYTE        = 8'hE7;
    localparam int          ADDR_W            = 16;
    localparam int          DATA_W            = 8 * PAYLOAD_BYTES_MAX;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_WAIT    = 5'b00001,
        PH_ADDR_HI = 5'b00010,
        PH_ADDR_LO = 5'b00100,
        PH_DATA    = 5'b01000,
        PH_CHECK   = 5'b10000
    } t_phase;

    // One recovered frame.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } t_frame;

endpackage

[rtl/adf_if.sv]
// Valid/ready channel interfaces for received bytes and recovered frames.
interface adf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface adf_frame_if;
    logic                         valid;
    logic                         ready;
    logic [adf_pkg::ADDR_W-1:0]   frame_address;
    logic [adf_pkg::DATA_W-1:0]   frame_data;

    modport source (output valid, output frame_address, output frame_data, input ready);
    modport sink   (input valid, input frame_address, input frame_data, output ready);
endinterface

[rtl/address_frame_deframer.sv]
// Top level of the address frame deframer: input register, parser, result register.
//
// Usage:
//   i_rx carries one received serial byte per item. Outside a frame the block
//   waits for start byte 0xE7, then takes a big-endian 16-bit address, the
//   payload bytes (first byte most significant) and a check byte equal to the
//   XOR of all address and payload bytes.
//   o_frame carries one item per frame whose check byte matched: the address
//   and the 64-bit payload. A frame with a bad check byte is dropped silently.
//   A start byte inside a frame is taken as an ordinary byte.
// Throughput: one byte per cycle unless o_frame stalls; the parser steps once per byte.
// Path: a check byte is first captured in the input register; the parser
//   judges the byte held there, and the result register takes the frame when
//   the parser steps on that byte.
// Reset: synchronous, active low; the parser returns to waiting for a start
//   byte and both registers are emptied.
// Stall: while o_frame.ready is low a pending result holds; one more byte is
//   held in the input register, and i_rx.ready then drops until the result
//   is taken.
module address_frame_deframer #(
    parameter int PAYLOAD_BYTES = adf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adf_rx_if.sink      i_rx,
    adf_frame_if.source o_frame
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_out_valid;
    adf_pkg::t_frame r_out;
    logic            advance;
    logic            hit;
    adf_pkg::t_frame frame;

    // process the held byte whenever the result register can take a result
    assign advance     = r_in_valid && (!r_out_valid || o_frame.ready);
    assign i_rx.ready  = !r_in_valid || advance;

    adf_parser #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_hit   (hit),
        .o_frame (frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= hit;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (advance && hit) begin
            r_out <= frame;
        end
    end

    assign o_frame.valid         = r_out_valid;
    assign o_frame.frame_address = r_out.address;
    assign o_frame.frame_data    = r_out.data;

endmodule

[rtl/adf_parser.sv]
// Byte-step frame parser: phase tracking, address/payload assembly, running check.
module adf_parser #(
    parameter int PAYLOAD_BYTES = adf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output logic            o_hit,
    output adf_pkg::t_frame o_frame
);

    localparam int CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

    adf_pkg::t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [adf_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [adf_pkg::DATA_W-1:0]   r_data, n_data;
    logic [7:0]                   r_check, n_check;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_addr  = r_addr;
        n_data  = r_data;
        n_check = r_check;
        o_hit   = 1'b0;
        if (i_step) begin
            unique case (r_phase)
                adf_pkg::PH_WAIT: begin
                    if (i_byte == adf_pkg::START_BYTE) begin
                        n_phase = adf_pkg::PH_ADDR_HI;
                        n_data  = '0;
                        n_check = '0;
                        n_cnt   = '0;
                    end
                end
                adf_pkg::PH_ADDR_HI: begin
                    n_addr[15:8] = i_byte;
                    n_check      = r_check ^ i_byte;
                    n_phase      = adf_pkg::PH_ADDR_LO;
                end
                adf_pkg::PH_ADDR_LO: begin
                    n_addr[7:0] = i_byte;
                    n_check     = r_check ^ i_byte;
                    n_phase     = adf_pkg::PH_DATA;
                end
                adf_pkg::PH_DATA: begin
                    // shift in at the low end, first byte ends most significant
                    n_data  = {r_data[adf_pkg::DATA_W-9:0], i_byte};
                    n_check = r_check ^ i_byte;
                    if (r_cnt == CNT_LAST) begin
                        n_phase = adf_pkg::PH_CHECK;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                adf_pkg::PH_CHECK: begin
                    o_hit   = (i_byte == r_check);
                    n_phase = adf_pkg::PH_WAIT;
                end
                default: begin
                    n_phase = adf_pkg::PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= adf_pkg::PH_WAIT;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_addr  <= n_addr;
        r_data  <= n_data;
        r_check <= n_check;
    end

    assign o_frame.address = r_addr;
    assign o_frame.data    = r_data;

endmodule

[rtl/adf_checker.sv]
// Port-level checks for the address frame deframer, bound to the top level.
module adf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_rx_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [adf_pkg::ADDR_W-1:0] i_out_address,
    input logic [adf_pkg::DATA_W-1:0] i_out_data
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_address) && $stable(i_out_data)))
        else $error("frame item changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("frame item valid after reset");

    // byte input never blocks unless a result is pending and stalled
    a_rx_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_rx_ready)
        else $error("byte input stalled without a pending result");

    // a result cannot appear in the first cycle after reset ends
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("frame item right after reset");

endmodule

bind address_frame_deframer adf_checker u_adf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rx_ready    (i_rx.ready),
    .i_out_valid   (o_frame.valid),
    .i_out_ready   (o_frame.ready),
    .i_out_address (o_frame.frame_address),
    .i_out_data    (o_frame.frame_data)
);

[sim/tb_top.sv]
// Testbench for the address frame deframer: byte table plus random frame streams, scoreboarded.
module tb_top;

    localparam int PB           = adf_pkg::PAYLOAD_BYTES_DEF;
    localparam int RANDOM_BYTES = 1500;
    localparam int QUIET_FROM   = 1300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_SHOWN    = 10;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_FRAME, ROW_NO_FRAME} t_row_kind;

    typedef struct {
        logic [7:0]      rx;
        t_row_kind       kind;
        adf_pkg::t_frame want;
    } t_row;

    localparam adf_pkg::t_frame FRAME_NONE = '0;
    localparam adf_pkg::t_frame FRAME_ONES = '{address: 16'hFFFF,
                                               data: 64'hFFFF_FFFF_FFFF_FFFF};

    logic        i_clk;
    logic        i_rst_n;
    adf_rx_if    rx_ch ();
    adf_frame_if fr_ch ();

    address_frame_deframer #(.PAYLOAD_BYTES(PB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_frame (fr_ch)
    );

    // Parser mirror and frames still owed by the block.
    adf_pkg::t_phase               parse_phase;
    int                            data_seen;
    logic [adf_pkg::ADDR_W-1:0]    addr_acc;
    logic [adf_pkg::DATA_W-1:0]    data_acc;
    adf_pkg::t_frame               frames_due [$];

    t_row                  directed_rows [25];
    adf_pkg::t_frame       head_frame;
    bit                    idle_on;
    int                    bytes_taken    = 0;
    int                    mismatch_count = 0;
    int                    frames_seen    = 0;
    int                    stall_left     = 0;
    int                    cycle_count    = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%s", msg);
    endtask

    // Step the parser mirror by one byte; return 0 when the byte is dropped while waiting.
    function automatic bit deframe_byte(input logic [7:0] b, output bit got,
                                        output adf_pkg::t_frame f);
        logic [7:0] sum;
        got = 1'b0;
        f = FRAME_NONE;
        deframe_byte = 1'b1;
        case (parse_phase)
            adf_pkg::PH_ADDR_HI: begin
                addr_acc = {b, 8'h00};
                parse_phase = adf_pkg::PH_ADDR_LO;
            end
            adf_pkg::PH_ADDR_LO: begin
                addr_acc[7:0] = b;
                data_seen = 0;
                parse_phase = adf_pkg::PH_DATA;
            end
            adf_pkg::PH_DATA: begin
                data_acc = {data_acc[adf_pkg::DATA_W-9:0], b};
                data_seen++;
                if (data_seen == PB)
                    parse_phase = adf_pkg::PH_CHECK;
            end
            adf_pkg::PH_CHECK: begin
                sum = addr_acc[15:8] ^ addr_acc[7:0];
                for (int k = 0; k < adf_pkg::DATA_W / 8; k++)
                    sum ^= data_acc[8*k +: 8];
                if (sum == b) begin
                    got = 1'b1;
                    f.address = addr_acc;
                    f.data = data_acc;
                end
                parse_phase = adf_pkg::PH_WAIT;
            end
            default: begin
                if (b == adf_pkg::START_BYTE) begin
                    data_acc = '0;
                    parse_phase = adf_pkg::PH_ADDR_HI;
                end else begin
                    parse_phase = adf_pkg::PH_WAIT;
                    deframe_byte = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return adf_pkg::START_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input t_row_kind kind,
                             input adf_pkg::t_frame want);
        int unsigned     gap;
        bit              got;
        bit              taken;
        adf_pkg::t_frame f;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        taken = deframe_byte(b, got, f);
        if (taken)
            bytes_taken++;
        case (kind)
            ROW_PREDICT: if (got) frames_due.push_back(f);
            ROW_FRAME:   frames_due.push_back(want);
            default:     ;
        endcase
    endtask

    task automatic send_frame(input logic [15:0] a, input logic [63:0] d, input bit corrupt);
        logic [7:0] chk;
        chk = a[15:8] ^ a[7:0];
        for (int k = 0; k < PB; k++)
            chk ^= d[8*k +: 8];
        if (corrupt)
            chk ^= 8'($urandom_range(1, 255));
        send_byte(adf_pkg::START_BYTE, ROW_PREDICT, FRAME_NONE);
        send_byte(a[15:8], ROW_PREDICT, FRAME_NONE);
        send_byte(a[7:0], ROW_PREDICT, FRAME_NONE);
        for (int k = PB - 1; k >= 0; k--)
            send_byte(d[8*k +: 8], ROW_PREDICT, FRAME_NONE);
        send_byte(chk, ROW_PREDICT, FRAME_NONE);
    endtask

    // Result side: random stall bursts while idling is on.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fr_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            fr_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            fr_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && fr_ch.valid && fr_ch.ready) begin
            frames_seen++;
            if (frames_due.size() == 0) begin
                flag_error($sformatf("frame %0d unexpected: address %h data %h",
                                     frames_seen, fr_ch.frame_address, fr_ch.frame_data));
            end else begin
                head_frame = frames_due.pop_front();
                if (fr_ch.frame_address !== head_frame.address ||
                    fr_ch.frame_data !== head_frame.data)
                    flag_error($sformatf("frame %0d: address exp %h got %h, data exp %h got %h",
                                         frames_seen, head_frame.address, fr_ch.frame_address,
                                         head_frame.data, fr_ch.frame_data));
            end
        end
    end

    initial begin
        int unsigned       r;
        int unsigned       n;
        logic [15:0]       a;
        logic [63:0]       d;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        idle_on <= 1'b1;
        i_rst_n <= 1'b0;
        parse_phase = adf_pkg::PH_WAIT;
        data_seen = 0;
        addr_acc = '0;
        data_acc = '0;

        // Noise byte, all-ones frame, then a frame with start bytes inside it and a bad check.
        directed_rows = '{
            '{8'h00, ROW_PREDICT, FRAME_NONE},
            '{adf_pkg::START_BYTE, ROW_PREDICT, FRAME_NONE},
            '{8'hFF, ROW_PREDICT, FRAME_NONE}, '{8'hFF, ROW_PREDICT, FRAME_NONE},
            '{8'hFF, ROW_PREDICT, FRAME_NONE}, '{8'hFF, ROW_PREDICT, FRAME_NONE},
            '{8'hFF, ROW_PREDICT, FRAME_NONE}, '{8'hFF, ROW_PREDICT, FRAME_NONE},
            '{8'hFF, ROW_PREDICT, FRAME_NONE}, '{8'hFF, ROW_PREDICT, FRAME_NONE},
            '{8'hFF, ROW_PREDICT, FRAME_NONE}, '{8'hFF, ROW_PREDICT, FRAME_NONE},
            '{8'h00, ROW_FRAME, FRAME_ONES},
            '{adf_pkg::START_BYTE, ROW_PREDICT, FRAME_NONE},
            '{adf_pkg::START_BYTE, ROW_PREDICT, FRAME_NONE},
            '{8'h00, ROW_PREDICT, FRAME_NONE},
            '{adf_pkg::START_BYTE, ROW_PREDICT, FRAME_NONE},
            '{8'h01, ROW_PREDICT, FRAME_NONE},
            '{8'h80, ROW_PREDICT, FRAME_NONE}, '{8'h00, ROW_PREDICT, FRAME_NONE},
            '{8'h00, ROW_PREDICT, FRAME_NONE}, '{8'h00, ROW_PREDICT, FRAME_NONE},
            '{8'h00, ROW_PREDICT, FRAME_NONE}, '{8'h7F, ROW_PREDICT, FRAME_NONE},
            '{8'hFF, ROW_NO_FRAME, FRAME_NONE}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_byte(directed_rows[k].rx, directed_rows[k].kind, directed_rows[k].want);

        // Mostly well-formed frames; some bad checks, cut-off frames and line noise.
        while (bytes_taken < RANDOM_BYTES) begin
            idle_on <= (bytes_taken < QUIET_FROM) && ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 82) begin
                a = {pick_byte(), pick_byte()};
                d = '0;
                for (int k = 0; k < PB; k++)
                    d[8*k +: 8] = pick_byte();
                send_frame(a, d, r >= 70);
            end else if (r < 90) begin
                send_byte(adf_pkg::START_BYTE, ROW_PREDICT, FRAME_NONE);
                n = $urandom_range(1, 10);
                repeat (n) send_byte(pick_byte(), ROW_PREDICT, FRAME_NONE);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)), ROW_PREDICT, FRAME_NONE);
            end
        end
        rx_ch.valid <= 1'b0;

        while (frames_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[address_frame_deframer.f]
rtl/adf_pkg.sv
rtl/adf_if.sv
rtl/adf_parser.sv
rtl/address_frame_deframer.sv
rtl/adf_checker.sv
sim/tb_top.sv
